FILE: src/jsd_pkg.sv
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared types, constants and the divider step for the joystick scaler.
// ----------------------------------------------------------------------------
package jsd_pkg;

    localparam int RAW_W  = 8;
    localparam int REM_W  = 15;   // holds up to 255 * 100
    localparam int QUO_W  = 7;    // quotient never exceeds 100
    localparam int PCT_W  = 8;
    localparam int SLD_W  = 7;
    localparam int DIR_W  = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic CFG_X_CENTRE = 1'b0;
    localparam logic CFG_Y_CENTRE = 1'b1;

    localparam logic [RAW_W-1:0] CENTRE_RESET = 8'd160;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_NEUTRAL = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UP      = 3'd4;
    localparam logic [DIR_W-1:0] DIR_WAITING = 3'd5;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RAW_W-1:0] div;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } jsd_axis_t;

    typedef struct packed {
        jsd_axis_t        x;
        jsd_axis_t        y;
        logic [SLD_W-1:0] left;
        logic [SLD_W-1:0] right;
        logic [DIR_W-1:0] prior;
    } jsd_item_t;

    // One restoring division step producing quotient bit number pos.
    function automatic jsd_axis_t div_step(input jsd_axis_t a, input int pos);
        jsd_axis_t        r;
        logic [REM_W-1:0] dsh;
        begin
            r   = a;
            dsh = REM_W'(a.div) << pos;
            if (a.rem >= dsh)
            begin
                r.rem      = a.rem - dsh;
                r.quo[pos] = 1'b1;
            end
            return r;
        end
    endfunction

endpackage

FILE: src/jsd_front.sv
// ----------------------------------------------------------------------------
// jsd_front
// First pipeline stage: forms dividends and divisors for the stick axes and
// scales the sliders by a constant reciprocal.
// ----------------------------------------------------------------------------
module jsd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [jsd_pkg::RAW_W-1:0]       x_centre,
    input  logic [jsd_pkg::RAW_W-1:0]       y_centre,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [jsd_pkg::RAW_W-1:0]       raw_x,
    input  logic [jsd_pkg::RAW_W-1:0]       raw_y,
    input  logic [jsd_pkg::RAW_W-1:0]       raw_left,
    input  logic [jsd_pkg::RAW_W-1:0]       raw_right,
    input  logic [jsd_pkg::DIR_W-1:0]       prior_direction,
    output logic                            out_valid,
    input  logic                            out_ready,
    output jsd_pkg::jsd_item_t              out_item
);

    logic               valid_reg;
    jsd_pkg::jsd_item_t item_reg;
    jsd_pkg::jsd_item_t item_next;

    function automatic jsd_pkg::jsd_axis_t axis_setup(
        input logic [jsd_pkg::RAW_W-1:0] raw,
        input logic [jsd_pkg::RAW_W-1:0] centre
    );
        jsd_pkg::jsd_axis_t        a;
        logic [jsd_pkg::RAW_W-1:0] n;
        logic [15:0]               prod;
        begin
            if (raw >= centre)
            begin
                n     = raw - centre;
                a.div = 8'd255 - centre;
                a.neg = 1'b0;
            end
            else
            begin
                n     = centre - raw;
                a.div = centre;
                a.neg = 1'b1;
            end
            // A zero span only occurs with a zero dividend, so any divisor works.
            if (a.div == '0)
                a.div = 8'd1;
            prod  = 16'(n) * 16'd100;
            a.rem = prod[jsd_pkg::REM_W-1:0];
            a.quo = '0;
            return a;
        end
    endfunction

    // value * 100 / 255, exact for every 8-bit input value.
    function automatic logic [jsd_pkg::SLD_W-1:0] slider_scale(
        input logic [jsd_pkg::RAW_W-1:0] raw
    );
        logic [16:0] p;
        logic [16:0] s;
        begin
            p = 17'(raw) * 17'd100 + 17'd1;
            s = p + (p >> 8);
            return s[14:8];
        end
    endfunction

    always_comb
    begin
        item_next.x     = axis_setup(raw_x, x_centre);
        item_next.y     = axis_setup(raw_y, y_centre);
        item_next.left  = slider_scale(raw_left);
        item_next.right = slider_scale(raw_right);
        item_next.prior = prior_direction;
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/jsd_div_stage.sv
// ----------------------------------------------------------------------------
// jsd_div_stage
// One pipelined restoring-division stage: resolves one quotient bit of both
// stick axes and carries the rest of the beat along.
// ----------------------------------------------------------------------------
module jsd_div_stage #(
    parameter int BIT_POS = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jsd_pkg::jsd_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output jsd_pkg::jsd_item_t out_item
);

    logic               valid_reg;
    jsd_pkg::jsd_item_t item_reg;
    jsd_pkg::jsd_item_t item_next;

    always_comb
    begin
        item_next   = in_item;
        item_next.x = jsd_pkg::div_step(in_item.x, BIT_POS);
        item_next.y = jsd_pkg::div_step(in_item.y, BIT_POS);
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: src/jsd_classify.sv
// ----------------------------------------------------------------------------
// jsd_classify
// Last stage: applies the axis signs, classifies the direction and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module jsd_classify (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  jsd_pkg::jsd_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [jsd_pkg::OUT_TDATA_W-1:0]     out_data
);

    logic                              valid_reg;
    logic [jsd_pkg::OUT_TDATA_W-1:0]   data_reg;
    logic [jsd_pkg::OUT_TDATA_W-1:0]   data_next;
    logic signed [jsd_pkg::PCT_W-1:0]  xp;
    logic signed [jsd_pkg::PCT_W-1:0]  yp;
    logic                              dead_zone;
    logic [jsd_pkg::DIR_W-1:0]         dir;

    always_comb
    begin
        xp = in_item.x.neg ? -$signed({1'b0, in_item.x.quo}) : $signed({1'b0, in_item.x.quo});
        yp = in_item.y.neg ? -$signed({1'b0, in_item.y.quo}) : $signed({1'b0, in_item.y.quo});

        dead_zone = (xp < 8'sd50) && (xp > -8'sd50) && (yp < 8'sd50) && (yp > -8'sd50);

        if (!dead_zone && (in_item.prior != jsd_pkg::DIR_NEUTRAL))
            dir = jsd_pkg::DIR_WAITING;
        else if (xp > 8'sd95)
            dir = jsd_pkg::DIR_RIGHT;
        else if (xp < -8'sd95)
            dir = jsd_pkg::DIR_LEFT;
        else if (yp < -8'sd95)
            dir = jsd_pkg::DIR_DOWN;
        else if (yp > 8'sd95)
            dir = jsd_pkg::DIR_UP;
        else
            dir = jsd_pkg::DIR_NEUTRAL;

        data_next = {7'd0, dir, in_item.right, in_item.left, yp, xp};
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: src/joystick_scale_and_direction.sv
// ----------------------------------------------------------------------------
// joystick_scale_and_direction
// Scales stick and slider samples to percent and classifies stick direction.
// ----------------------------------------------------------------------------
// Pipeline: front stage, seven one-bit divider stages, then the classify
// stage, which holds the output register.
// Throughput: one beat per cycle while nothing stalls; each stage stalls independently, so
// bubbles are squeezed out under back-pressure.
// Reset: all stage valid bits clear; both centres return to 160.
module joystick_scale_and_direction (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_x, raw_y, raw_left, raw_right, prior_direction, zero fill
    input  logic [jsd_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // x_percent, y_percent, left_percent, right_percent, direction, zero fill
    output logic [jsd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int DIV_STAGES = jsd_pkg::QUO_W;

    logic [7:0]         x_centre_reg;
    logic [7:0]         y_centre_reg;
    logic               stg_valid [DIV_STAGES+1];
    logic               stg_ready [DIV_STAGES+1];
    jsd_pkg::jsd_item_t stg_item  [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_centre_reg <= jsd_pkg::CENTRE_RESET;
            y_centre_reg <= jsd_pkg::CENTRE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jsd_pkg::CFG_X_CENTRE: x_centre_reg <= cfg_data;
                jsd_pkg::CFG_Y_CENTRE: y_centre_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    jsd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .x_centre        (x_centre_reg),
        .y_centre        (y_centre_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .raw_x           (s_tdata[7:0]),
        .raw_y           (s_tdata[15:8]),
        .raw_left        (s_tdata[23:16]),
        .raw_right       (s_tdata[31:24]),
        .prior_direction (s_tdata[34:32]),
        .out_valid       (stg_valid[0]),
        .out_ready       (stg_ready[0]),
        .out_item        (stg_item[0])
    );

    // Stage k resolves quotient bit (DIV_STAGES-1-k), most significant first.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        jsd_div_stage #(
            .BIT_POS (DIV_STAGES - 1 - k)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    jsd_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[DIV_STAGES]),
        .in_ready  (stg_ready[DIV_STAGES]),
        .in_item   (stg_item[DIV_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

FILE: dv/joystick_scale_and_direction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_scale_and_direction_tb
// Self-checking bench for the joystick scaler and direction classifier. Each
// accepted sample set is turned into an expected reading by a local model of
// the percent scaling and the direction rule. Every output beat is compared
// field by field against the oldest pending reading. Directed sets run at the
// reset centres, and random sets under several centre calibrations. Both stream sides
// idle at random, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------
module joystick_scale_and_direction_tb;

    // Input beat, fields from the highest bit down.
    typedef struct packed {
        logic [4:0] fill;
        logic [2:0] prior;
        logic [7:0] raw_right;
        logic [7:0] raw_left;
        logic [7:0] raw_y;
        logic [7:0] raw_x;
    } sample_set_t;

    // Output beat, fields from the highest bit down.
    typedef struct packed {
        logic [6:0] fill;
        logic [2:0] direction;
        logic [6:0] right_pct;
        logic [6:0] left_pct;
        logic [7:0] y_pct;
        logic [7:0] x_pct;
    } reading_t;

    class joystick_scoreboard;
        logic [7:0] x_centre;
        logic [7:0] y_centre;
        reading_t   pending_readings[$];
        int         error_count;

        function new();
            x_centre    = jsd_pkg::CENTRE_RESET;
            y_centre    = jsd_pkg::CENTRE_RESET;
            error_count = 0;
        endfunction

        // Signed percent of the span from the centre to the end on that side.
        function int axis_percent(int raw, int centre);
            if (raw >= centre)
            begin
                if (centre == 255)
                    return 0;
                return ((raw - centre) * 100) / (255 - centre);
            end
            return -(((centre - raw) * 100) / centre);
        endfunction

        function logic [2:0] stick_direction(int xp, int yp, logic [2:0] prior);
            logic [2:0] p;
            p = prior;
            // Inside the dead zone any previous direction counts as neutral.
            if (xp < 50 && xp > -50 && yp < 50 && yp > -50)
                p = jsd_pkg::DIR_NEUTRAL;
            if (p != jsd_pkg::DIR_NEUTRAL)
                return jsd_pkg::DIR_WAITING;
            if (xp > 95)
                return jsd_pkg::DIR_RIGHT;
            if (xp < -95)
                return jsd_pkg::DIR_LEFT;
            if (yp < -95)
                return jsd_pkg::DIR_DOWN;
            if (yp > 95)
                return jsd_pkg::DIR_UP;
            return jsd_pkg::DIR_NEUTRAL;
        endfunction

        function reading_t scale_and_classify(sample_set_t s);
            reading_t r;
            int       xp;
            int       yp;
            xp          = axis_percent(int'(s.raw_x), int'(x_centre));
            yp          = axis_percent(int'(s.raw_y), int'(y_centre));
            r           = '0;
            r.x_pct     = 8'(xp);
            r.y_pct     = 8'(yp);
            r.left_pct  = 7'((int'(s.raw_left) * 100) / 255);
            r.right_pct = 7'((int'(s.raw_right) * 100) / 255);
            r.direction = stick_direction(xp, yp, s.prior);
            return r;
        endfunction

        function void note_sample_set(sample_set_t s);
            pending_readings.push_back(scale_and_classify(s));
        endfunction

        function void check_reading(reading_t got);
            reading_t exp_r;
            if (pending_readings.size() == 0)
            begin
                $error("output beat with no reading pending: %h", got);
                error_count++;
                return;
            end
            exp_r = pending_readings.pop_front();
            if (got.x_pct !== exp_r.x_pct)
            begin
                $error("x_percent: expected %0d, got %0d",
                       $signed(exp_r.x_pct), $signed(got.x_pct));
                error_count++;
            end
            if (got.y_pct !== exp_r.y_pct)
            begin
                $error("y_percent: expected %0d, got %0d",
                       $signed(exp_r.y_pct), $signed(got.y_pct));
                error_count++;
            end
            if (got.left_pct !== exp_r.left_pct)
            begin
                $error("left_percent: expected %0d, got %0d", exp_r.left_pct, got.left_pct);
                error_count++;
            end
            if (got.right_pct !== exp_r.right_pct)
            begin
                $error("right_percent: expected %0d, got %0d",
                       exp_r.right_pct, got.right_pct);
                error_count++;
            end
            if (got.direction !== exp_r.direction)
            begin
                $error("direction: expected %0d, got %0d", exp_r.direction, got.direction);
                error_count++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic                            cfg_index;
    logic [7:0]                      cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    // raw_x, raw_y, raw_left, raw_right, prior_direction, zero fill
    logic [jsd_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // x_percent, y_percent, left_percent, right_percent, direction, zero fill
    logic [jsd_pkg::OUT_TDATA_W-1:0] m_tdata;

    joystick_scoreboard sb;
    bit                 no_idle;
    int                 long_hold;

    joystick_scale_and_direction dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_sample_set(sample_set_t'(s_tdata));
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(reading_t'(m_tdata));
    end

    function automatic sample_set_t make_set(int x, int y, int l, int r, int p);
        sample_set_t s;
        s           = '0;
        s.raw_x     = 8'(x);
        s.raw_y     = 8'(y);
        s.raw_left  = 8'(l);
        s.raw_right = 8'(r);
        s.prior     = 3'(p);
        return s;
    endfunction

    // Biased toward the ends and the centre so that every direction shows up.
    function automatic logic [7:0] pick_raw(logic [7:0] centre);
        int v;
        case ($urandom_range(0, 4)) inside
            0, 1: v = $urandom_range(0, 255);
            2:    v = $urandom_range(0, 12);
            3:    v = $urandom_range(243, 255);
            default:
            begin
                v = int'(centre) + int'($urandom_range(0, 40)) - 20;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
        endcase
        return 8'(v);
    endfunction

    task automatic send_sample_set(input sample_set_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drains the pipeline before the centres are written.
    task automatic set_centres(input logic [7:0] xc, input logic [7:0] yc);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_readings.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= jsd_pkg::CFG_X_CENTRE;
        cfg_data  <= xc;
        @(posedge clk);
        cfg_index <= jsd_pkg::CFG_Y_CENTRE;
        cfg_data  <= yc;
        @(posedge clk);
        cfg_we      <= 1'b0;
        sb.x_centre = xc;
        sb.y_centre = yc;
    endtask

    // Directed sets, run with both centres at 160.
    task automatic run_directed();
        send_sample_set(make_set(0, 0, 0, 0, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(255, 255, 255, 255, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(160, 160, 128, 1, jsd_pkg::DIR_RIGHT));
        send_sample_set(make_set(160, 0, 254, 3, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(160, 255, 2, 253, jsd_pkg::DIR_NEUTRAL));
        // Left wins over a y deflection, right over down.
        send_sample_set(make_set(0, 255, 77, 178, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(255, 0, 51, 204, jsd_pkg::DIR_NEUTRAL));
        // Any non-neutral previous code outside the dead zone gives waiting.
        send_sample_set(make_set(255, 160, 10, 20, jsd_pkg::DIR_LEFT));
        send_sample_set(make_set(255, 160, 30, 40, jsd_pkg::DIR_WAITING));
        send_sample_set(make_set(160, 0, 50, 60, 6));
        send_sample_set(make_set(0, 160, 70, 80, 7));
        // Just inside and just past the right and left thresholds, then just past up and down.
        send_sample_set(make_set(251, 160, 90, 100, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(252, 160, 110, 120, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(7, 160, 130, 140, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(6, 160, 150, 170, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(160, 252, 190, 200, jsd_pkg::DIR_NEUTRAL));
        send_sample_set(make_set(160, 6, 210, 220, jsd_pkg::DIR_NEUTRAL));
        // Dead zone edges on both sides with a stale previous direction.
        send_sample_set(make_set(207, 160, 230, 240, jsd_pkg::DIR_DOWN));
        send_sample_set(make_set(208, 160, 250, 5, jsd_pkg::DIR_DOWN));
        send_sample_set(make_set(81, 160, 15, 25, jsd_pkg::DIR_UP));
        send_sample_set(make_set(80, 160, 35, 45, jsd_pkg::DIR_UP));
        send_sample_set(make_set(160, 80, 55, 65, 7));
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_sample_set(make_set(pick_raw(sb.x_centre), pick_raw(sb.y_centre),
                                     $urandom_range(0, 255), $urandom_range(0, 255),
                                     ($urandom_range(0, 9) < 6)
                                         ? int'(jsd_pkg::DIR_NEUTRAL)
                                         : $urandom_range(0, 7)));
        end
    endtask

    // Output side: a random stall before every beat, or a long one on request.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                stall     = long_hold;
                long_hold = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        #5_000_000;
        $display("[joystick_scale_and_direction] ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] x_settings[9];
        logic [7:0] y_settings[9];
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = jsd_pkg::CFG_X_CENTRE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        no_idle   = 1'b0;
        long_hold = 0;

        // Calibrated range ends, then the degenerate centres 0 and 255.
        x_settings = '{8'd160, 8'd1, 8'd254, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd160};
        y_settings = '{8'd160, 8'd254, 8'd1, 8'd255, 8'd0, 8'd37, 8'd0, 8'd0, 8'd160};
        x_settings[6] = $urandom_range(1, 254);
        y_settings[6] = $urandom_range(1, 254);
        x_settings[7] = $urandom_range(0, 255);
        y_settings[7] = $urandom_range(0, 255);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph > 0)
                set_centres(x_settings[ph], y_settings[ph]);
            // Hold the output off long enough for the pipeline to fill.
            if (ph == 1)
                long_hold = 300;
            run_random(160);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_readings.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_readings.size() == 0)
            $display("[joystick_scale_and_direction] OK");
        else
            $display("[joystick_scale_and_direction] ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
src/jsd_pkg.sv
src/jsd_front.sv
src/jsd_div_stage.sv
src/jsd_classify.sv
src/joystick_scale_and_direction.sv
dv/joystick_scale_and_direction_tb.sv
